### rtl/core/lfps_pkg.sv
// Shared types, widths and codes for the line-follower PID steering block.
package lfps_pkg;

	localparam int MAX_SENSORS_DEF = 8;
	localparam int GAIN_FRAC_DEF   = 8;

	localparam int READ_W     = 8;
	localparam int CNT_W      = 4;
	localparam int WEIGHT_W   = 5;
	localparam int ERR_W      = 13;
	localparam int DERIV_W    = ERR_W + 1;
	localparam int INTEG_W    = 32;
	localparam int GAIN_W     = 16;
	localparam int BASE_W     = 15;
	localparam int SPEED_W    = 16;
	localparam int PROD_W     = GAIN_W + INTEG_W;
	localparam int ACC_W      = PROD_W + 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CNT_W-1:0]  COUNT_RESET     = CNT_W'(8);
	localparam logic [READ_W-1:0] THRESHOLD_RESET = READ_W'(128);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SENSOR_COUNT = 3'd0,
		REG_GAIN_P       = 3'd1,
		REG_GAIN_I       = 3'd2,
		REG_GAIN_D       = 3'd3,
		REG_BASE_SPEED   = 3'd4,
		REG_THRESHOLD    = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PID_IDLE,
		PID_INTEG,
		PID_MUL_P,
		PID_MUL_I,
		PID_MUL_D,
		PID_SUM,
		PID_SCALE,
		PID_DONE
	} pid_state_t;

	typedef struct packed {
		logic [READ_W-1:0] reading_0;
		logic [READ_W-1:0] reading_1;
		logic [READ_W-1:0] reading_2;
		logic [READ_W-1:0] reading_3;
		logic [READ_W-1:0] reading_4;
		logic [READ_W-1:0] reading_5;
		logic [READ_W-1:0] reading_6;
		logic [READ_W-1:0] reading_7;
	} in_item_t;

	typedef struct packed {
		logic signed [SPEED_W-1:0] right_speed;
		logic signed [SPEED_W-1:0] left_speed;
		logic signed [SPEED_W-1:0] correction;
		logic                      junction;
	} out_item_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic [BASE_W-1:0]        base_speed;
	} pid_cfg_t;

	typedef struct packed {
		logic start;
		logic out_free;
	} pid_ctrl_t;

	typedef struct packed {
		logic busy;
		logic res_valid;
	} pid_stat_t;

endpackage

### rtl/core/lfps_lane.sv
// One sensor lane: weighted reading and line-seen check.
module lfps_lane import lfps_pkg::*; #(
	parameter int LANE_IDX = 0
) (
	input  logic                     clk,
	input  logic                     load,
	input  logic [READ_W-1:0]        reading,
	input  logic [CNT_W-1:0]         count,
	input  logic [CNT_W-2:0]         half,
	input  logic [READ_W-1:0]        threshold,
	output logic signed [ERR_W-1:0]  prod_s1,
	output logic                     on_s1
);

	logic                        used;
	logic signed [WEIGHT_W-1:0]  weight;
	logic signed [ERR_W:0]       prod;

	assign used   = CNT_W'(LANE_IDX) < count;
	assign weight = $signed({1'b0, (WEIGHT_W-1)'(LANE_IDX)}) - $signed({2'b0, half});
	assign prod   = $signed({1'b0, reading}) * weight;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= used ? prod[ERR_W-1:0] : '0;
			on_s1   <= !used || (reading >= threshold);
		end
	end

endmodule

### rtl/core/lfps_merge.sv
// Merge stage: sum lane products into the line error, and-combine line-seen flags.
module lfps_merge import lfps_pkg::*; #(
	parameter int NUM_LANES = MAX_SENSORS_DEF
) (
	input  logic                     clk,
	input  logic                     load,
	input  logic signed [ERR_W-1:0]  prod [NUM_LANES],
	input  logic [NUM_LANES-1:0]     on,
	output logic signed [ERR_W-1:0]  err_s2,
	output logic                     junction_s2
);

	logic signed [ERR_W-1:0] sum;

	// true error stays within +/-2550, so a 13-bit sum never wraps
	always_comb begin
		sum = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			sum = sum + prod[i];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			err_s2      <= sum;
			junction_s2 <= &on;
		end
	end

endmodule

### rtl/core/lfps_pid.sv
// PID sequencer: integral/derivative update and one shared multiplier for three gains.
module lfps_pid import lfps_pkg::*; #(
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pid_cfg_t                 cfg,
	input  pid_ctrl_t                ctrl,
	input  logic signed [ERR_W-1:0]  err,
	input  logic                     junction,
	output pid_stat_t                stat,
	output out_item_t                res
);

	pid_state_t state_q, state_next;

	logic signed [INTEG_W-1:0] integ_q;
	logic signed [ERR_W-1:0]   prev_q;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [DERIV_W-1:0] deriv_q;
	logic                      junc_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [SPEED_W-1:0] corr_q;

	logic signed [GAIN_W-1:0]  mul_a;
	logic signed [INTEG_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_y;
	logic                      acc_init, acc_add;

	logic signed [INTEG_W:0]   integ_sum;
	logic signed [INTEG_W-1:0] integ_sat;
	logic signed [ACC_W-1:0]   scaled;
	logic signed [SPEED_W-1:0] corr_sat;
	logic signed [SPEED_W:0]   right_sum, left_sum;
	logic signed [SPEED_W-1:0] right_sat, left_sat;

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			PID_IDLE:  if (ctrl.start) state_next = PID_INTEG;
			PID_INTEG: state_next = PID_MUL_P;
			PID_MUL_P: state_next = PID_MUL_I;
			PID_MUL_I: state_next = PID_MUL_D;
			PID_MUL_D: state_next = PID_SUM;
			PID_SUM:   state_next = PID_SCALE;
			PID_SCALE: state_next = PID_DONE;
			PID_DONE:  if (ctrl.out_free) state_next = PID_IDLE;
			default:   state_next = PID_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		mul_a          = '0;
		mul_b          = '0;
		acc_init       = 1'b0;
		acc_add        = 1'b0;
		stat.busy      = (state_q != PID_IDLE);
		stat.res_valid = (state_q == PID_DONE);
		case (state_q)
			PID_MUL_P: begin
				mul_a = cfg.gain_p;
				mul_b = INTEG_W'(err_q);
			end
			PID_MUL_I: begin
				mul_a    = cfg.gain_i;
				mul_b    = integ_q;
				acc_init = 1'b1;
			end
			PID_MUL_D: begin
				mul_a   = cfg.gain_d;
				mul_b   = INTEG_W'(deriv_q);
				acc_add = 1'b1;
			end
			PID_SUM: acc_add = 1'b1;
			default: ;
		endcase
	end

	assign mul_y = mul_a * mul_b;

	// saturating integral
	assign integ_sum = INTEG_W'(0) + {integ_q[INTEG_W-1], integ_q} + (INTEG_W+1)'(err_q);
	always_comb begin
		if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1])
			integ_sat = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
			                               : {1'b0, {(INTEG_W-1){1'b1}}};
		else
			integ_sat = integ_sum[INTEG_W-1:0];
	end

	// floor shift, then clamp to 16 bits
	assign scaled = acc_q >>> GAIN_FRAC_BITS;
	always_comb begin
		if ((&scaled[ACC_W-1:SPEED_W-1]) || !(|scaled[ACC_W-1:SPEED_W-1]))
			corr_sat = scaled[SPEED_W-1:0];
		else
			corr_sat = scaled[ACC_W-1] ? {1'b1, {(SPEED_W-1){1'b0}}}
			                           : {1'b0, {(SPEED_W-1){1'b1}}};
	end

	assign right_sum = $signed({2'b0, cfg.base_speed}) + (SPEED_W+1)'(corr_q);
	assign left_sum  = $signed({2'b0, cfg.base_speed}) - (SPEED_W+1)'(corr_q);

	always_comb begin
		right_sat = right_sum[SPEED_W-1:0];
		left_sat  = left_sum[SPEED_W-1:0];
		if (right_sum[SPEED_W] != right_sum[SPEED_W-1])
			right_sat = right_sum[SPEED_W] ? {1'b1, {(SPEED_W-1){1'b0}}}
			                               : {1'b0, {(SPEED_W-1){1'b1}}};
		if (left_sum[SPEED_W] != left_sum[SPEED_W-1])
			left_sat = left_sum[SPEED_W] ? {1'b1, {(SPEED_W-1){1'b0}}}
			                             : {1'b0, {(SPEED_W-1){1'b1}}};
	end

	assign res.right_speed = right_sat;
	assign res.left_speed  = left_sat;
	assign res.correction  = corr_q;
	assign res.junction    = junc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PID_IDLE;
			integ_q <= '0;
			prev_q  <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == PID_INTEG) begin
				integ_q <= integ_sat;
				prev_q  <= err_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == PID_IDLE && ctrl.start) begin
			err_q  <= err;
			junc_q <= junction;
		end
		if (state_q == PID_INTEG)
			deriv_q <= DERIV_W'(err_q) - DERIV_W'(prev_q);
		prod_q <= mul_y;
		if (acc_init)
			acc_q <= ACC_W'(prod_q);
		else if (acc_add)
			acc_q <= acc_q + ACC_W'(prod_q);
		if (state_q == PID_SCALE)
			corr_q <= corr_sat;
	end

endmodule

### rtl/core/line_follow_pid_steer.sv
// Line-follower PID steering controller: one sensor frame in, one steering result out.
// Each accepted frame runs through the sensor lanes and the merge stage, then through
// the PID sequencer, whose single 16x32 multiplier forms the three gain products one
// after another; the result then passes through the output register to out_item.
// One frame is in flight at a time, and a new frame is taken once the previous result
// has moved into the output register. The error integral and previous error start
// at zero after reset. Configuration writes take effect at once and belong in idle
// time only.
module line_follow_pid_steer import lfps_pkg::*; #(
	parameter int MAX_SENSORS    = MAX_SENSORS_DEF,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_item,
	input  logic                  cfg_write_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [CNT_W-1:0]  count_q;
	logic [READ_W-1:0] threshold_q;
	pid_cfg_t          pid_cfg_q;

	logic [CNT_W-1:0]  count_used;
	logic [CNT_W-2:0]  half;
	logic [READ_W-1:0] rd [8];

	logic in_accept;
	logic v_s1, v_s2;

	logic signed [ERR_W-1:0] prod_s1 [MAX_SENSORS];
	logic [MAX_SENSORS-1:0]  on_s1;
	logic signed [ERR_W-1:0] err_s2;
	logic                    junction_s2;

	pid_ctrl_t pid_ctrl;
	pid_stat_t pid_stat;
	out_item_t pid_res;

	logic      out_valid_q;
	out_item_t out_item_q;
	logic      out_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= COUNT_RESET;
			threshold_q <= THRESHOLD_RESET;
			pid_cfg_q   <= '0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_SENSOR_COUNT: count_q              <= cfg_data[CNT_W-1:0];
				REG_GAIN_P:       pid_cfg_q.gain_p     <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:       pid_cfg_q.gain_i     <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:       pid_cfg_q.gain_d     <= cfg_data[GAIN_W-1:0];
				REG_BASE_SPEED:   pid_cfg_q.base_speed <= cfg_data[BASE_W-1:0];
				REG_THRESHOLD:    threshold_q          <= cfg_data[READ_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp sensor count to 1..MAX_SENSORS
	always_comb begin
		if (count_q == '0)
			count_used = CNT_W'(1);
		else if (count_q > CNT_W'(MAX_SENSORS))
			count_used = CNT_W'(MAX_SENSORS);
		else
			count_used = count_q;
	end
	assign half = count_used[CNT_W-1:1];

	assign rd[0] = in_item.reading_0;
	assign rd[1] = in_item.reading_1;
	assign rd[2] = in_item.reading_2;
	assign rd[3] = in_item.reading_3;
	assign rd[4] = in_item.reading_4;
	assign rd[5] = in_item.reading_5;
	assign rd[6] = in_item.reading_6;
	assign rd[7] = in_item.reading_7;

	// one frame in flight: lanes, merge and sequencer all empty
	assign in_stall  = v_s1 || v_s2 || pid_stat.busy;
	assign in_accept = in_valid && !in_stall;

	for (genvar g = 0; g < MAX_SENSORS; g++) begin : g_lane
		lfps_lane #(.LANE_IDX(g)) u_lane (
			.clk       (clk),
			.load      (in_accept),
			.reading   (rd[g]),
			.count     (count_used),
			.half      (half),
			.threshold (threshold_q),
			.prod_s1   (prod_s1[g]),
			.on_s1     (on_s1[g])
		);
	end

	lfps_merge #(.NUM_LANES(MAX_SENSORS)) u_merge (
		.clk         (clk),
		.load        (v_s1),
		.prod        (prod_s1),
		.on          (on_s1),
		.err_s2      (err_s2),
		.junction_s2 (junction_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_accept;
			v_s2 <= v_s1;
		end
	end

	assign out_free          = !out_valid_q || !out_stall;
	assign pid_ctrl.start    = v_s2;
	assign pid_ctrl.out_free = out_free;

	lfps_pid #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_pid (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (pid_cfg_q),
		.ctrl     (pid_ctrl),
		.err      (err_s2),
		.junction (junction_s2),
		.stat     (pid_stat),
		.res      (pid_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pid_stat.res_valid && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pid_stat.res_valid && out_free)
			out_item_q <= pid_res;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// at most one frame anywhere in the lanes, merge and sequencer
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({v_s1, v_s2, pid_stat.busy}))
		else $error("more than one frame in flight");

	// a finished result moves into the output register on the next edge
	a_result_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pid_stat.res_valid && out_free |=> out_valid && !pid_stat.res_valid)
		else $error("finished result not loaded");

	// the output register only fills from the sequencer
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(pid_stat.res_valid))
		else $error("result appeared without sequencer completion");

endmodule
